[rtl/ini_line_tokenizer_unit_defines.svh]
// Assertion macros shared by the tokenizer RTL.
// Each macro expects clk and rst_n to be in scope.
`ifndef INI_LINE_TOKENIZER_UNIT_DEFINES_SVH
`define INI_LINE_TOKENIZER_UNIT_DEFINES_SVH

// same-cycle implication
`define ILT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ILT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ilt_pkg.sv]
// Shared types and constants for the INI line tokenizer.
// No dependencies.
package ilt_pkg;

  localparam int DEF_POSITION_BITS = 32;
  localparam int DEF_LENGTH_BITS   = 16;
  localparam int LEN_FIELD_MAX     = 65535;

  // record kinds
  localparam logic [2:0] KIND_EMPTY   = 3'd0;
  localparam logic [2:0] KIND_COMMENT = 3'd1;
  localparam logic [2:0] KIND_SECTION = 3'd2;
  localparam logic [2:0] KIND_VALUE   = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // characters of interest
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } ilt_item_t;

  typedef struct packed {
    logic [2:0]  line_kind;
    logic [31:0] key_start;
    logic [15:0] key_size;
    logic [31:0] text_start;
    logic [15:0] text_length;
  } ilt_rec_t;

endpackage

[rtl/ilt_in_reg.sv]
// Input register stage of the tokenizer.
// Depends on ilt_pkg for the item type.
module ilt_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ilt_pkg::ilt_item_t in_item,
  input  logic               fire,
  output logic               stage_valid,
  output ilt_pkg::ilt_item_t stage_item
);

  logic               valid_r;
  logic               valid_nxt;
  ilt_pkg::ilt_item_t item_r;

  assign in_ready    = !valid_r || fire;
  assign stage_valid = valid_r;
  assign stage_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

[rtl/ilt_parser.sv]
// Line parser: mode register, position counter and trim trackers.
// Depends on ilt_pkg and ini_line_tokenizer_unit_defines.svh.
`include "ini_line_tokenizer_unit_defines.svh"

module ilt_parser #(
  parameter int POSITION_BITS = ilt_pkg::DEF_POSITION_BITS,
  parameter int LENGTH_BITS   = ilt_pkg::DEF_LENGTH_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  ilt_pkg::ilt_item_t item,
  output logic               emit,
  output ilt_pkg::ilt_rec_t  rec
);

  localparam int PW = POSITION_BITS + 1;
  localparam logic [PW-1:0] LEN_CAP = (LENGTH_BITS < 16) ?
                                      PW'((64'd1 << LENGTH_BITS) - 64'd1) :
                                      PW'(ilt_pkg::LEN_FIELD_MAX);

  localparam logic [2:0] MODE_LINE    = 3'd0;
  localparam logic [2:0] MODE_AFTER   = 3'd1;
  localparam logic [2:0] MODE_COMMENT = 3'd2;
  localparam logic [2:0] MODE_SECTION = 3'd3;
  localparam logic [2:0] MODE_KEY     = 3'd4;
  localparam logic [2:0] MODE_VALUE   = 3'd5;
  localparam logic [2:0] MODE_HALTED  = 3'd6;

  typedef logic [POSITION_BITS-1:0] pos_t;

  function automatic logic [15:0] span_len(input pos_t first, input pos_t last);
    logic [PW-1:0] n;
    n = {1'b0, last - first} + PW'(1);
    return (n > LEN_CAP) ? LEN_CAP[15:0] : n[15:0];
  endfunction

  function automatic logic [31:0] pos32(input pos_t v);
    logic [POSITION_BITS+31:0] w;
    w = {32'd0, v};
    return w[31:0];
  endfunction

  logic [2:0]  mode_r,   mode_nxt;
  logic        blanks_r, blanks_nxt;
  pos_t        pos_r,    pos_nxt;
  pos_t        fstart_r, fstart_nxt;
  pos_t        first_r,  first_nxt;
  pos_t        last_r,   last_nxt;
  logic        seen_r,   seen_nxt;
  pos_t        kstart_r, kstart_nxt;
  logic [15:0] klen_r,   klen_nxt;

  logic [7:0]  b;
  logic        is_blank;
  logic        is_trim;
  logic [15:0] right_len;
  pos_t        both_start;
  logic [15:0] both_len;
  logic        do_line;
  logic        do_key;
  logic        rec_error;
  logic        rec_bare;
  logic        rec_clear;
  logic        byte_step;

  assign b        = item.text_byte;
  assign is_blank = (b == ilt_pkg::CH_SPACE) || (b == ilt_pkg::CH_TAB) ||
                    (b == ilt_pkg::CH_VT);
  assign is_trim  = is_blank || (b == ilt_pkg::CH_NL) || (b == ilt_pkg::CH_FF) ||
                    (b == ilt_pkg::CH_CR);

  assign right_len  = seen_r ? span_len(fstart_r, last_r) : 16'd0;
  assign both_start = seen_r ? first_r : fstart_r;
  assign both_len   = seen_r ? span_len(first_r, last_r) : 16'd0;

  always_comb begin
    mode_nxt   = mode_r;
    blanks_nxt = blanks_r;
    pos_nxt    = pos_r;
    fstart_nxt = fstart_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    seen_nxt   = seen_r;
    kstart_nxt = kstart_r;
    klen_nxt   = klen_r;
    emit       = 1'b0;
    rec        = '0;
    do_line    = 1'b0;
    do_key     = 1'b0;

    if (fire && (mode_r != MODE_HALTED)) begin
      if (item.end_of_text) begin
        // flush pending line, then back to the reset state unless it errors
        unique case (mode_r)
          MODE_LINE: begin
            if (blanks_r) begin
              emit           = 1'b1;
              rec.line_kind  = ilt_pkg::KIND_EMPTY;
            end
          end
          MODE_COMMENT: begin
            emit             = 1'b1;
            rec.line_kind    = ilt_pkg::KIND_COMMENT;
            rec.text_start   = pos32(fstart_r);
            rec.text_length  = right_len;
          end
          MODE_VALUE: begin
            emit             = 1'b1;
            rec.line_kind    = ilt_pkg::KIND_VALUE;
            rec.key_start    = pos32(kstart_r);
            rec.key_size     = klen_r;
            rec.text_start   = pos32(fstart_r);
            rec.text_length  = right_len;
          end
          MODE_SECTION, MODE_KEY: begin
            emit             = 1'b1;
            rec.line_kind    = ilt_pkg::KIND_ERROR;
          end
          default: begin
          end
        endcase
        if (emit && (rec.line_kind == ilt_pkg::KIND_ERROR)) begin
          mode_nxt = MODE_HALTED;
        end else begin
          mode_nxt   = MODE_LINE;
          blanks_nxt = 1'b0;
          pos_nxt    = '0;
          fstart_nxt = '0;
          first_nxt  = '0;
          last_nxt   = '0;
          seen_nxt   = 1'b0;
          kstart_nxt = '0;
          klen_nxt   = '0;
        end
      end else begin
        pos_nxt = pos_r + POSITION_BITS'(1);
        unique case (mode_r)
          MODE_LINE: begin
            do_line = 1'b1;
          end
          MODE_AFTER: begin
            // one newline right after ']' is swallowed
            mode_nxt   = MODE_LINE;
            blanks_nxt = 1'b0;
            do_line    = (b != ilt_pkg::CH_NL);
          end
          MODE_COMMENT, MODE_VALUE: begin
            if (b == ilt_pkg::CH_NL) begin
              emit            = 1'b1;
              rec.line_kind   = (mode_r == MODE_VALUE) ? ilt_pkg::KIND_VALUE :
                                                         ilt_pkg::KIND_COMMENT;
              if (mode_r == MODE_VALUE) begin
                rec.key_start  = pos32(kstart_r);
                rec.key_size   = klen_r;
              end
              rec.text_start  = pos32(fstart_r);
              rec.text_length = right_len;
              mode_nxt        = MODE_LINE;
              blanks_nxt      = 1'b0;
            end else if (!is_trim) begin
              if (!seen_r) begin
                first_nxt = pos_r;
              end
              seen_nxt = 1'b1;
              last_nxt = pos_r;
            end
          end
          MODE_SECTION: begin
            if (b == ilt_pkg::CH_NL) begin
              emit          = 1'b1;
              rec.line_kind = ilt_pkg::KIND_ERROR;
              mode_nxt      = MODE_HALTED;
            end else if (b == ilt_pkg::CH_RBRK) begin
              emit            = 1'b1;
              rec.line_kind   = ilt_pkg::KIND_SECTION;
              rec.text_start  = pos32(both_start);
              rec.text_length = both_len;
              mode_nxt        = MODE_AFTER;
            end else if (!is_trim) begin
              if (!seen_r) begin
                first_nxt = pos_r;
              end
              seen_nxt = 1'b1;
              last_nxt = pos_r;
            end
          end
          MODE_KEY: begin
            do_key = 1'b1;
          end
          default: begin
            mode_nxt = MODE_HALTED;
          end
        endcase

        if (do_line) begin
          if (is_blank) begin
            blanks_nxt = 1'b1;
          end else if (b == ilt_pkg::CH_NL) begin
            blanks_nxt    = 1'b0;
            emit          = 1'b1;
            rec.line_kind = ilt_pkg::KIND_EMPTY;
          end else begin
            fstart_nxt = pos_r + POSITION_BITS'(1);
            first_nxt  = '0;
            last_nxt   = '0;
            seen_nxt   = 1'b0;
            blanks_nxt = 1'b0;
            if (b == ilt_pkg::CH_SEMI) begin
              mode_nxt = MODE_COMMENT;
            end else if (b == ilt_pkg::CH_LBRK) begin
              mode_nxt = MODE_SECTION;
            end else begin
              mode_nxt   = MODE_KEY;
              fstart_nxt = pos_r;
              do_key     = 1'b1;
            end
          end
        end

        if (do_key) begin
          if (b == ilt_pkg::CH_EQ) begin
            // a key opened by this very byte is empty and starts here
            if (mode_r == MODE_KEY) begin
              kstart_nxt = both_start;
              klen_nxt   = both_len;
            end else begin
              kstart_nxt = pos_r;
              klen_nxt   = 16'd0;
            end
            mode_nxt   = MODE_VALUE;
            fstart_nxt = pos_r + POSITION_BITS'(1);
            first_nxt  = '0;
            last_nxt   = '0;
            seen_nxt   = 1'b0;
            blanks_nxt = 1'b0;
          end else if (!is_trim) begin
            if (!seen_nxt) begin
              first_nxt = pos_r;
            end
            seen_nxt = 1'b1;
            last_nxt = pos_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_LINE;
      blanks_r <= 1'b0;
      pos_r    <= '0;
      fstart_r <= '0;
      first_r  <= '0;
      last_r   <= '0;
      seen_r   <= 1'b0;
      kstart_r <= '0;
      klen_r   <= '0;
    end else begin
      mode_r   <= mode_nxt;
      blanks_r <= blanks_nxt;
      pos_r    <= pos_nxt;
      fstart_r <= fstart_nxt;
      first_r  <= first_nxt;
      last_r   <= last_nxt;
      seen_r   <= seen_nxt;
      kstart_r <= kstart_nxt;
      klen_r   <= klen_nxt;
    end
  end

  assign rec_error = emit && (rec.line_kind == ilt_pkg::KIND_ERROR);
  assign rec_bare  = emit && ((rec.line_kind == ilt_pkg::KIND_EMPTY) || rec_error);
  assign rec_clear = (rec.key_size == 16'd0) && (rec.text_length == 16'd0) &&
                     (rec.text_start == 32'd0);
  assign byte_step = fire && !item.end_of_text && (mode_r != MODE_HALTED);

  `ILT_ASSERT_NOW(a_halt_silent, mode_r == MODE_HALTED, !emit, "record while halted")
  `ILT_ASSERT_NEXT(a_error_halts, rec_error, mode_r == MODE_HALTED, "no halt after error")
  `ILT_ASSERT_NOW(a_bare_fields, rec_bare, rec_clear, "fields set in bare record")
  `ILT_ASSERT_NEXT(a_pos_step, byte_step, pos_r == $past(pos_r) + POSITION_BITS'(1), "no step")

endmodule

[rtl/ilt_out_reg.sv]
// Result register stage of the tokenizer.
// Depends on ilt_pkg for the record type.
module ilt_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              emit,
  input  ilt_pkg::ilt_rec_t rec,
  input  logic              out_ready,
  output logic              out_valid,
  output ilt_pkg::ilt_rec_t out_rec
);

  logic              valid_r;
  logic              valid_nxt;
  ilt_pkg::ilt_rec_t rec_r;

  assign out_valid = valid_r;
  assign out_rec   = rec_r;

  always_comb begin
    valid_nxt = valid_r;
    if (fire && emit) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      rec_r <= rec;
    end
  end

endmodule

[rtl/ini_line_tokenizer_unit.sv]
// A record reaches the result register once its item has passed the input register and the parser
// (input register, then the parser into the result register); a waiting record can hold the item back.
// Throughput: one item per cycle; the result register only stalls intake while a record waits.
// Each item is a single registered pass through the parser mode logic.
// Reset (synchronous, active low) empties both registers and returns the parser to line start.
module ini_line_tokenizer_unit #(
  parameter int POSITION_BITS = ilt_pkg::DEF_POSITION_BITS,
  parameter int LENGTH_BITS   = ilt_pkg::DEF_LENGTH_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_line_kind,
  output logic [31:0] out_key_start,
  output logic [15:0] out_key_size,
  output logic [31:0] out_text_start,
  output logic [15:0] out_text_length
);

  ilt_pkg::ilt_item_t in_item;
  ilt_pkg::ilt_item_t stage_item;
  ilt_pkg::ilt_rec_t  rec;
  ilt_pkg::ilt_rec_t  out_rec;
  logic               stage_valid;
  logic               fire;
  logic               emit;

  assign in_item.text_byte   = in_text_byte;
  assign in_item.end_of_text = in_end_of_text;

  // staged item moves whenever the result slot is free or draining
  assign fire = stage_valid && (!out_valid || out_ready);

  ilt_in_reg u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .fire        (fire),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  ilt_parser #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (stage_item),
    .emit  (emit),
    .rec   (rec)
  );

  ilt_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .emit      (emit),
    .rec       (rec),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_rec   (out_rec)
  );

  assign out_line_kind   = out_rec.line_kind;
  assign out_key_start   = out_rec.key_start;
  assign out_key_size    = out_rec.key_size;
  assign out_text_start  = out_rec.text_start;
  assign out_text_length = out_rec.text_length;

endmodule
